[src/multi_voice_waveform_oscillator_core_defines.svh]
// Assertion macros for the multi-voice oscillator core.
// Needs a clock named clk and a reset named rst in the module that uses them.
`ifndef MULTI_VOICE_WAVEFORM_OSCILLATOR_CORE_DEFINES_SVH
`define MULTI_VOICE_WAVEFORM_OSCILLATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// check outside reset
`define MVWO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check at every edge, reset included
`define MVWO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MVWO_ASSERT(label, prop, msg)
`define MVWO_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[src/mvwo_pkg.sv]
// Shared widths, constants, codes and control structs of the oscillator core.
// No dependencies.
`default_nettype none
package mvwo_pkg;
  localparam int NUM_VOICES = 8;
  localparam int VOICE_W    = 3;
  localparam int CMD_W      = 2;
  localparam int FREQ_W     = 23;
  localparam int AMP_W      = 7;
  localparam int SHAPE_W    = 7;
  localparam int CNT_W      = 25;
  localparam int LEN_W      = 24;
  localparam int STEP_W     = 40;
  localparam int SAMPLE_W   = 24;
  localparam int HALF_W     = 20;
  localparam int PART_W     = CNT_W + HALF_W;
  localparam int PROD_W     = CNT_W + STEP_W;
  localparam int DIV_CNT_W  = 6;
  localparam int OP_W       = 2;

  // peak level: amplitude * full scale / 127 without a divider
  localparam int PX_W     = 10;
  localparam int PR_W     = 11;
  localparam int PR_SHIFT = 17;
  // high length: shape * period / 100 by reciprocal multiplication
  localparam int HP_W        = SHAPE_W + LEN_W;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 34;
  localparam int HQ_W        = HP_W - 2 + RECIP_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 24'hFFFFFF;
  localparam logic [LEN_W-1:0]    PERIOD_MAX      = 24'hFFFFFF;
  localparam logic [SAMPLE_W-1:0] PULSE_LOW_RESET = 24'h100000;
  localparam logic [STEP_W-1:0]   PERIOD_NUM      = 40'd24576000;
  // floor(0xFFFFFF / 127) and 0xFFFFFF mod 127
  localparam logic [LEN_W-1:0]    PEAK_MULT       = 24'd132104;
  localparam logic [2:0]          PEAK_REM        = 3'd7;
  // ceil(2^17 / 127), exact for dividends below 2^10
  localparam logic [PR_W-1:0]     PEAK_RECIP      = 11'd1033;
  // ceil(2^34 / 25), exact for dividends below 2^29
  localparam logic [RECIP_W-1:0]  SHAPE_RECIP     = 30'd687194768;

  // waveform kinds
  localparam logic [CMD_W-1:0] KIND_PULSE = 2'd0;
  localparam logic [CMD_W-1:0] KIND_SAW   = 2'd1;
  localparam logic [CMD_W-1:0] KIND_TRI   = 2'd2;
  localparam logic [CMD_W-1:0] KIND_NONE  = 2'd3;

  // division steps of a restart
  localparam logic [OP_W-1:0] OP_PERIOD = 2'd0;
  localparam logic [OP_W-1:0] OP_RISE   = 2'd1;
  localparam logic [OP_W-1:0] OP_FALL   = 2'd2;

  // config register addresses
  localparam logic PULSE_LOW_ADDR = 1'b0;

  typedef struct packed {
    logic            accept;
    logic            load;
    logic            restart;
    logic            div_start;
    logic            div_store;
    logic [OP_W-1:0] op;
    logic            high_mul;
    logic            high_set;
    logic            prep;
    logic            mul_lo;
    logic            mul_hi;
    logic            finish;
  } dp_cmd_t;

  typedef struct packed {
    logic             restart;
    logic [CMD_W-1:0] kind;
    logic             div_done;
    logic             out_free;
  } dp_status_t;
endpackage
`default_nettype wire

[src/mvwo_div.sv]
// Restoring divider, one quotient bit per cycle, 40-bit dividend by 24-bit divisor.
// Uses mvwo_pkg. A zero divisor yields all ones; callers handle that case.
`default_nettype none
module mvwo_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [mvwo_pkg::STEP_W-1:0]      dividend,
  input  wire  [mvwo_pkg::LEN_W-1:0]       divisor,
  output logic                             done,
  output logic [mvwo_pkg::STEP_W-1:0]      quotient
);
  import mvwo_pkg::*;

  logic [LEN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LEN_W:0]       rem_sh;
  logic                 fits;

  // shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, quotient[STEP_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CNT_W'(STEP_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (cnt != '0) begin
      quotient <= {quotient[STEP_W-2:0], fits};
      rem      <= fits ? LEN_W'(rem_sh - {1'b0, divisor}) : rem_sh[LEN_W-1:0];
    end
  end
endmodule
`default_nettype wire

[src/mvwo_ctrl.sv]
// Sequencer of the oscillator core: input handshake and the order of divide,
// multiply and finish steps. Uses mvwo_pkg.
`default_nettype none
module mvwo_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  mvwo_pkg::dp_status_t    status,
  output mvwo_pkg::dp_cmd_t       cmd
);
  import mvwo_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOAD     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_DIV_GO   = 4'd3;
  localparam logic [3:0] S_DIV_WAIT = 4'd4;
  localparam logic [3:0] S_PREP     = 4'd5;
  localparam logic [3:0] S_MUL_LO   = 4'd6;
  localparam logic [3:0] S_MUL_HI   = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;
  localparam logic [3:0] S_HIGH_MUL = 4'd9;
  localparam logic [3:0] S_HIGH     = 4'd10;

  logic [3:0]      state, state_next;
  logic [OP_W-1:0] op, op_next;

  assign in_ready = (state == S_IDLE);

  // pick the next state and the next division step
  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_CHECK;
      S_CHECK: begin
        if (status.restart) begin
          op_next    = OP_PERIOD;
          state_next = S_DIV_GO;
        end else begin
          state_next = S_PREP;
        end
      end
      S_DIV_GO: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_DIV_GO;
          case (op)
            OP_PERIOD: begin
              if (status.kind == KIND_SAW) op_next = OP_RISE;
              else state_next = S_HIGH_MUL;
            end
            OP_RISE: begin
              if (status.kind == KIND_TRI) op_next = OP_FALL;
              else state_next = S_PREP;
            end
            default: state_next = S_PREP;
          endcase
        end
      end
      S_HIGH_MUL: state_next = S_HIGH;
      S_HIGH: begin
        if (status.kind == KIND_TRI) begin
          op_next    = OP_RISE;
          state_next = S_DIV_GO;
        end else begin
          state_next = S_PREP;
        end
      end
      S_PREP:   state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_FINISH;
      S_FINISH: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_PERIOD;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // drive datapath commands
  always_comb begin
    cmd           = '0;
    cmd.accept    = in_valid && in_ready;
    cmd.load      = (state == S_LOAD);
    cmd.restart   = (state == S_CHECK) && status.restart;
    cmd.div_start = (state == S_DIV_GO);
    cmd.div_store = (state == S_DIV_WAIT) && status.div_done;
    cmd.op        = op;
    cmd.high_mul  = (state == S_HIGH_MUL);
    cmd.high_set  = (state == S_HIGH);
    cmd.prep      = (state == S_PREP);
    cmd.mul_lo    = (state == S_MUL_LO);
    cmd.mul_hi    = (state == S_MUL_HI);
    cmd.finish    = (state == S_FINISH) && status.out_free;
  end
endmodule
`default_nettype wire

[src/mvwo_dp.sv]
// Datapath of the oscillator core: per-voice state, divider operands,
// split multiplier, sample shaping and output register. Uses mvwo_pkg, mvwo_div.
`default_nettype none
`include "multi_voice_waveform_oscillator_core_defines.svh"
module mvwo_dp (
  input  wire                              clk,
  input  wire                              rst,
  input  mvwo_pkg::dp_cmd_t                cmd,
  output mvwo_pkg::dp_status_t             status,
  input  wire  [mvwo_pkg::CMD_W-1:0]       command,
  input  wire  [mvwo_pkg::VOICE_W-1:0]     voice,
  input  wire  [mvwo_pkg::FREQ_W-1:0]      frequency_q8,
  input  wire  [mvwo_pkg::AMP_W-1:0]       amplitude,
  input  wire  [mvwo_pkg::SHAPE_W-1:0]     shape_setting,
  input  wire  [mvwo_pkg::SAMPLE_W-1:0]    pulse_low_level,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mvwo_pkg::SAMPLE_W-1:0]    sample
);
  import mvwo_pkg::*;

  // per-voice state
  logic [CNT_W-1:0]  count_mem  [NUM_VOICES];
  logic [LEN_W-1:0]  period_mem [NUM_VOICES];
  logic [LEN_W-1:0]  high_mem   [NUM_VOICES];
  logic [LEN_W-1:0]  low_mem    [NUM_VOICES];
  logic [LEN_W-1:0]  peak_mem   [NUM_VOICES];
  logic [STEP_W-1:0] rise_mem   [NUM_VOICES];
  logic [STEP_W-1:0] fall_mem   [NUM_VOICES];

  // captured request
  logic [CMD_W-1:0]   kind_r;
  logic [VOICE_W-1:0] voice_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [AMP_W-1:0]   amp_r;
  logic [SHAPE_W-1:0] shape_r;

  // working copy of the selected voice
  logic [CNT_W-1:0]  w_count;
  logic [LEN_W-1:0]  w_period, w_high, w_low, w_peak;
  logic [STEP_W-1:0] w_rise, w_fall;

  logic [STEP_W-1:0] dvd, quotient;
  logic [LEN_W-1:0]  dvs;
  logic              div_done;
  logic [LEN_W-1:0]  high_q;

  logic [PX_W-1:0]      peak_x;
  logic [PX_W+PR_W-1:0] peak_fix;
  logic [LEN_W-1:0]     peak_calc;
  logic [HP_W-1:0]      high_prod;
  logic [HQ_W-1:0]      high_full;
  logic [CNT_W-1:0]     high_quo;

  logic [CNT_W-1:0]  mul_a;
  logic [STEP_W-1:0] mul_b;
  logic [HALF_W-1:0] mul_half;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic              rising, rising_r;
  logic              fall_sel;

  logic [STEP_W-1:0]   top;
  logic [SAMPLE_W-1:0] sample_next;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= command;
      voice_r <= voice;
      freq_r  <= frequency_q8;
      amp_r   <= amplitude;
      shape_r <= shape_setting;
    end
  end

  // divider operands for each step
  always_comb begin
    case (cmd.op)
      OP_PERIOD: begin
        dvd = PERIOD_NUM;
        dvs = {1'b0, freq_r};
      end
      OP_RISE: begin
        dvd = {w_peak, 16'b0};
        dvs = (kind_r == KIND_SAW) ? w_period : w_high;
      end
      OP_FALL: begin
        dvd = {w_peak, 16'b0};
        dvs = w_low;
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  mvwo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  // peak = amp * 0xFFFFFF / 127, split as amp * 132104 + floor(7 * amp / 127)
  assign peak_x    = PX_W'(amp_r) * PX_W'(PEAK_REM);
  assign peak_fix  = (PX_W+PR_W)'(peak_x) * (PX_W+PR_W)'(PEAK_RECIP);
  assign peak_calc = LEN_W'(amp_r) * PEAK_MULT + LEN_W'(peak_fix[PX_W+PR_W-1:PR_SHIFT]);

  // high = shape * period / 100, taken as (x / 4) / 25 by reciprocal multiply
  assign high_full = HQ_W'(high_prod[HP_W-1:2]) * HQ_W'(SHAPE_RECIP);
  assign high_quo  = high_full[HQ_W-1:RECIP_SHIFT];

  // high length saturates at the period
  assign high_q = (high_quo > {1'b0, w_period}) ? w_period : high_quo[LEN_W-1:0];

  // pick multiplier operands: rising side counts from zero, falling side from high
  assign rising   = (kind_r != KIND_TRI) || (w_count <= {1'b0, w_high});
  assign mul_half = cmd.mul_hi ? mul_b[STEP_W-1:HALF_W] : mul_b[HALF_W-1:0];
  assign part     = {{HALF_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, mul_half};
  assign fall_sel = (kind_r == KIND_TRI) && !rising_r;

  // working copy: load, restart, divide results, high length, multiply
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_count  <= count_mem[voice_r];
      w_period <= period_mem[voice_r];
      w_high   <= high_mem[voice_r];
      w_low    <= low_mem[voice_r];
      w_peak   <= peak_mem[voice_r];
      w_rise   <= rise_mem[voice_r];
      w_fall   <= fall_mem[voice_r];
    end
    if (cmd.restart) begin
      w_peak  <= peak_calc;
      w_count <= '0;
    end
    if (cmd.div_store) begin
      case (cmd.op)
        OP_PERIOD: begin
          if (freq_r != '0) begin
            w_period <= (quotient > STEP_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                         : quotient[LEN_W-1:0];
          end
        end
        OP_RISE: w_rise <= (dvs == '0) ? '0 : quotient;
        OP_FALL: w_fall <= (dvs == '0) ? '0 : quotient;
        default: ;
      endcase
    end
    if (cmd.high_mul) high_prod <= HP_W'(shape_r) * HP_W'(w_period);
    if (cmd.high_set) begin
      w_high <= high_q;
      if (kind_r == KIND_TRI) w_low <= w_period - high_q;
    end
    if (cmd.prep) begin
      mul_a    <= rising ? w_count : w_count - {1'b0, w_high};
      mul_b    <= rising ? w_rise : w_fall;
      rising_r <= rising;
    end
    if (cmd.mul_lo) prod <= {{HALF_W{1'b0}}, part};
    if (cmd.mul_hi) prod <= prod + {part, {HALF_W{1'b0}}};
  end

  // shape the sample
  assign top = {w_peak, 16'b0};
  always_comb begin
    if (kind_r == KIND_NONE || freq_r == '0) begin
      sample_next = '0;
    end else if (kind_r == KIND_PULSE) begin
      sample_next = (w_count <= {1'b0, w_high}) ? w_peak : pulse_low_level;
    end else if (!fall_sel) begin
      sample_next = (prod[PROD_W-1:STEP_W] != '0) ? SAMPLE_MAX : prod[STEP_W-1:16];
    end else begin
      sample_next = (PROD_W'(top) > prod) ? SAMPLE_W'((top - prod[STEP_W-1:0]) >> 16)
                                          : '0;
    end
  end

  // write back the voice and advance its count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        count_mem[i]  <= '0;
        period_mem[i] <= '0;
        high_mem[i]   <= '0;
        low_mem[i]    <= '0;
        peak_mem[i]   <= '0;
        rise_mem[i]   <= '0;
        fall_mem[i]   <= '0;
      end
    end else if (cmd.finish && kind_r != KIND_NONE) begin
      count_mem[voice_r]  <= w_count + 1'b1;
      period_mem[voice_r] <= w_period;
      high_mem[voice_r]   <= w_high;
      low_mem[voice_r]    <= w_low;
      peak_mem[voice_r]   <= w_peak;
      rise_mem[voice_r]   <= w_rise;
      fall_mem[voice_r]   <= w_fall;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) sample <= sample_next;
  end

  always_comb begin
    status.restart  = (kind_r != KIND_NONE) && (w_count > {1'b0, w_period});
    status.kind     = kind_r;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

  `MVWO_ASSERT(a_high_le_period, cmd.high_set |=> (w_high <= w_period), "high length above period")
  `MVWO_ASSERT(a_zero_freq, (cmd.finish && freq_r == '0) |=> (sample == '0), "nonzero sample at zero frequency")
  `MVWO_ASSERT(a_fall_le_peak, (cmd.finish && fall_sel && freq_r != '0) |=> (sample <= w_peak), "falling sample above peak")
  `MVWO_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid after reset")
endmodule
`default_nettype wire

[src/multi_voice_waveform_oscillator_core.sv]
// Top level of the multi-voice oscillator: config register port, sequencer, datapath.
// Uses mvwo_pkg, mvwo_ctrl, mvwo_dp.
`default_nettype none
// Eight-voice pulse / sawtooth / triangle oscillator. Each request is one sample
// tick for one voice and returns one 24-bit sample. A tick that does not restart
// its voice passes the load, the restart check, the operand prep, the two-pass
// 25x20 multiplier and the finish step on its way to the output register; the
// next request can be taken in the cycle after the finish step. A tick whose voice
// passes its period restarts it: the peak and the high length come from
// multiplications without a divider, and the period and the slopes from one shared
// bit-serial divider. Pulse divides for the period only, sawtooth for the period
// and the rising slope, triangle for the period and both slopes. The finish step
// waits while the output register holds an unaccepted sample. A new request is
// taken while the last sample waits in the output register. pulse_low_level is
// written at byte address 0 of the APB port and reads back there.
module multi_voice_waveform_oscillator_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [2:0]                       paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [mvwo_pkg::CMD_W-1:0]       command,
  input  wire  [mvwo_pkg::VOICE_W-1:0]     voice,
  input  wire  [mvwo_pkg::FREQ_W-1:0]      frequency_q8,
  input  wire  [mvwo_pkg::AMP_W-1:0]       amplitude,
  input  wire  [mvwo_pkg::SHAPE_W-1:0]     shape_setting,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mvwo_pkg::SAMPLE_W-1:0]    sample
);
  import mvwo_pkg::*;

  logic [SAMPLE_W-1:0] pulse_low_level;
  dp_cmd_t             cmd;
  dp_status_t          status;

  assign pready = 1'b1;

  // config register write
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_low_level <= PULSE_LOW_RESET;
    end else if (psel && penable && pwrite && paddr[2] == PULSE_LOW_ADDR) begin
      pulse_low_level <= pwdata[SAMPLE_W-1:0];
    end
  end

  // config register read
  assign prdata = (paddr[2] == PULSE_LOW_ADDR) ? 32'(pulse_low_level) : '0;

  mvwo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mvwo_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .command         (command),
    .voice           (voice),
    .frequency_q8    (frequency_q8),
    .amplitude       (amplitude),
    .shape_setting   (shape_setting),
    .pulse_low_level (pulse_low_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample          (sample)
  );
endmodule
`default_nettype wire
